// File: src/assert_macros.svh
// Assertion macros shared by the quantizer modules.
// Each macro expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The consequent must hold at the clock after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/spq_pkg.sv
// Types, constants and the fixed colour palette of the subsampled palette quantizer.
// No dependencies.
package spq_pkg;

   localparam int PALETTE_SIZE   = 16;
   localparam int SUBSAMPLE_STEP = 3;
   localparam int MAX_WIDTH      = 4096;

   localparam int IDX_W   = 4;
   localparam int DIST_W  = 10;
   localparam int WIDTH_W = 13;
   localparam int POS_W   = $clog2(MAX_WIDTH);
   localparam int PHASE_W = $clog2(SUBSAMPLE_STEP + 1);
   localparam int ADDR_W  = 3;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;
   localparam logic [ADDR_W-3:0]  REG_IMAGE_WIDTH = 1'b0;

   localparam logic [7:0] AT_B = 8'h10;
   localparam logic [7:0] AT_G = 8'h20;
   localparam logic [7:0] AT_R = 8'h40;
   localparam logic [7:0] AT_I = 8'h80;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] attr;
   } pal_entry_type;

   localparam pal_entry_type PALETTE [PALETTE_SIZE] = '{
      '{8'd197, 8'd15,  8'd31,  AT_R},
      '{8'd19,  8'd161, 8'd14,  AT_G},
      '{8'd0,   8'd55,  8'd218, AT_B},
      '{8'd136, 8'd23,  8'd152, AT_B | AT_R},
      '{8'd58,  8'd150, 8'd221, AT_B | AT_G},
      '{8'd193, 8'd156, 8'd0,   AT_R | AT_G},
      '{8'd204, 8'd204, 8'd204, AT_B | AT_R | AT_G},
      '{8'd12,  8'd12,  8'd12,  8'h00},
      '{8'd231, 8'd72,  8'd86,  AT_R | AT_I},
      '{8'd22,  8'd198, 8'd12,  AT_G | AT_I},
      '{8'd59,  8'd120, 8'd255, AT_B | AT_I},
      '{8'd180, 8'd0,   8'd158, AT_B | AT_R | AT_I},
      '{8'd97,  8'd214, 8'd214, AT_B | AT_G | AT_I},
      '{8'd249, 8'd241, 8'd165, AT_R | AT_G | AT_I},
      '{8'd242, 8'd242, 8'd242, AT_B | AT_R | AT_G | AT_I},
      '{8'd118, 8'd118, 8'd118, AT_I}
   };

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] palette_index;
      logic [7:0]       attribute;
      logic             row_end;
   } rsp_type;

   typedef struct packed {
      logic keep;
      logic row_end;
   } scan_type;

   typedef struct packed {
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic [IDX_W-1:0]  best_idx;
      logic [DIST_W-1:0] best_dist;
      logic              row_end;
   } stage_type;

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// File: src/subsampled_palette_quantizer.sv
// Top level of the subsampled palette quantizer: register port, position
// tracking and the chain of palette cells. Depends on spq_pkg, spq_scan, spq_cell.
//
// Usage: pixels arrive in raster order on the req_ channel (valid/stall); an
// item is taken at an edge with req_valid high and req_stall low. frame_start
// marks the first pixel of a frame. Only pixels in every third column of every
// third row produce a result; the others are consumed and produce nothing.
// Each result on the rsp_ channel carries the nearest palette index by sum of
// absolute channel differences (lowest index on ties), its background
// attribute byte and a flag on the last kept pixel of a row.
// A result is presented when its pixel has passed through one registered
// cell per palette entry (16 cells) in the chain.
// Throughput: one item per cycle while the receiver does not stall; each cell
// holds one item and forwards it once the next cell can take it, so empty cells
// close up even while the output waits. When the receiver stalls, the last cell
// holds its result and the stall propagates back cell by cell; req_stall rises
// only once all cells are full. Reset clears the position to row 0, column 0,
// empties the chain and sets image_width to 640. image_width is written through
// the register port at byte address 0 and is read back there.
module subsampled_palette_quantizer
   import spq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [WIDTH_W-1:0] width_ff;
   logic               accept;
   scan_type           scan;
   logic               chain_valid [PALETTE_SIZE+1];
   logic               chain_ready [PALETTE_SIZE+1];
   stage_type          chain_data  [PALETTE_SIZE+1];
   logic               reg_hit;

   assign pready  = 1'b1;
   assign reg_hit = paddr[ADDR_W-1:2] == REG_IMAGE_WIDTH;
   assign prdata  = reg_hit ? 32'(width_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (psel && penable && pwrite && pready && reg_hit) begin
         width_ff <= pwdata[WIDTH_W-1:0];
      end
   end

   assign req_stall = !chain_ready[0];
   assign accept    = req_valid && !req_stall;

   spq_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_data.frame_start),
      .image_width (width_ff),
      .scan        (scan)
   );

   always_comb begin
      chain_valid[0]          = req_valid && scan.keep;
      chain_data[0].red       = req_data.red;
      chain_data[0].green     = req_data.green;
      chain_data[0].blue      = req_data.blue;
      chain_data[0].best_idx  = '0;
      chain_data[0].best_dist = '1;
      chain_data[0].row_end   = scan.row_end;
   end

   for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (chain_valid[i]),
         .up_data    (chain_data[i]),
         .entry      (PALETTE[i]),
         .entry_idx  (IDX_W'(i)),
         .down_ready (chain_ready[i+1]),
         .up_ready   (chain_ready[i]),
         .down_valid (chain_valid[i+1]),
         .down_data  (chain_data[i+1])
      );
   end

   assign chain_ready[PALETTE_SIZE] = !rsp_stall;
   assign rsp_valid                 = chain_valid[PALETTE_SIZE];

   always_comb begin
      rsp_data.palette_index = chain_data[PALETTE_SIZE].best_idx;
      rsp_data.attribute     = PALETTE[chain_data[PALETTE_SIZE].best_idx].attr;
      rsp_data.row_end       = chain_data[PALETTE_SIZE].row_end;
   end

endmodule

// File: src/spq_scan.sv
// Raster position tracking: decides which pixels are kept and marks row ends.
// Depends on spq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spq_scan
   import spq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               frame_start,
   input  logic [WIDTH_W-1:0] image_width,
   output scan_type           scan
);

   logic [POS_W-1:0]   pos_ff, pos_in, cur_pos;
   logic [PHASE_W-1:0] col_ff, col_in, cur_col;
   logic [PHASE_W-1:0] row_ff, row_in, cur_row;
   logic [WIDTH_W-1:0] eff_width;
   logic               wrap;

   always_comb begin
      priority if (image_width == '0) begin
         eff_width = WIDTH_W'(1);
      end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
         eff_width = WIDTH_W'(MAX_WIDTH);
      end else begin
         eff_width = image_width;
      end
   end

   always_comb begin
      cur_pos = frame_start ? '0 : pos_ff;
      cur_col = frame_start ? '0 : col_ff;
      cur_row = frame_start ? '0 : row_ff;
      scan.keep = (cur_row == '0) && (cur_col == '0);
      scan.row_end = ((WIDTH_W+1)'(cur_pos) + (WIDTH_W+1)'(SUBSAMPLE_STEP))
                     >= (WIDTH_W+1)'(eff_width);
      wrap = WIDTH_W'(cur_pos) >= (eff_width - WIDTH_W'(1));
      if (wrap) begin
         pos_in = '0;
         col_in = '0;
         row_in = (((PHASE_W+1)'(cur_row) + (PHASE_W+1)'(1)) >= (PHASE_W+1)'(SUBSAMPLE_STEP))
                  ? '0 : cur_row + PHASE_W'(1);
      end else begin
         pos_in = cur_pos + POS_W'(1);
         col_in = (((PHASE_W+1)'(cur_col) + (PHASE_W+1)'(1)) >= (PHASE_W+1)'(SUBSAMPLE_STEP))
                  ? '0 : cur_col + PHASE_W'(1);
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   `SPQ_ASSERT_ALWAYS(a_phase_range,
      ((PHASE_W+1)'(col_ff) < (PHASE_W+1)'(SUBSAMPLE_STEP)) &&
      ((PHASE_W+1)'(row_ff) < (PHASE_W+1)'(SUBSAMPLE_STEP)),
      "Subsampling phase out of range.")
   `SPQ_ASSERT_ALWAYS(a_row_start_phase, (pos_ff != '0) || (col_ff == '0),
      "Column phase is not zero at the start of a row.")

endmodule

// File: src/spq_cell.sv
// One cell of the distance chain: compares the pixel with one palette entry
// and passes the running best match on. Depends on spq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spq_cell
   import spq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             up_valid,
   input  stage_type        up_data,
   input  pal_entry_type    entry,
   input  logic [IDX_W-1:0] entry_idx,
   input  logic             down_ready,
   output logic             up_ready,
   output logic             down_valid,
   output stage_type        down_data
);

   logic              valid_ff;
   stage_type         data_ff, data_in;
   logic [DIST_W-1:0] entry_dist;

   always_comb begin
      entry_dist = DIST_W'(abs_diff(up_data.red, entry.red))
                 + DIST_W'(abs_diff(up_data.green, entry.green))
                 + DIST_W'(abs_diff(up_data.blue, entry.blue));
      data_in = up_data;
      if (entry_dist < up_data.best_dist) begin
         data_in.best_dist = entry_dist;
         data_in.best_idx  = entry_idx;
      end
   end

   assign up_ready   = !valid_ff || down_ready;
   assign down_valid = valid_ff;
   assign down_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   `SPQ_ASSERT_NEXT(a_hold_when_blocked, valid_ff && !down_ready,
      valid_ff && $stable(data_ff), "Cell lost or changed a blocked item.")
   `SPQ_ASSERT_NEXT(a_dist_never_grows, up_valid && up_ready,
      data_ff.best_dist <= $past(up_data.best_dist), "Best distance grew along the chain.")

endmodule
